// ----- hw/rtl/rbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the 3x3 raster blur / sharpen filter.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = ADDR_W + 1;
    localparam int HEIGHT_W  = 16;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int WIN_CELLS = 9;
    localparam int IDX_W     = $clog2(WIN_CELLS);
    localparam int CENTER    = 4;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = 20;
    localparam int QCNT_W    = $clog2(NUM_W);
    localparam int CFG_IDX_W = 3;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_DRAIN     = 1'b1;
    localparam logic MODE_BLUR    = 1'b0;
    localparam logic MODE_SHARPEN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_FILTER_MODE,
        CFG_CENTER_WEIGHT,
        CFG_EDGE_WEIGHT,
        CFG_CORNER_WEIGHT,
        CFG_SHARPEN_GAIN
    } t_cfg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [HEIGHT_W-1:0] image_height;
        logic                filter_mode;
        logic [WEIGHT_W-1:0] center_weight;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [WEIGHT_W-1:0] corner_weight;
        logic [GAIN_W-1:0]   sharpen_gain;
    } t_cfg;

    typedef struct packed {
        logic              capture;
        logic              mem_rd;
        logic              mem_wr;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic              shift;
        logic              mac_start;
        logic              mac_step;
        logic              mac_ok;
        logic [IDX_W-1:0]  mac_idx;
        logic              mac_flush;
        logic              prep;
        logic              gain;
        logic              div_start;
        logic              out_load;
        logic              frame_last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/rbs_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_in_if
// Sample request channel: valid/ready handshake with op and sample payload.
// ----------------------------------------------------------------------------
interface rbs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [rbs_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output op, output sample_value, input ready);
    modport sink (input valid, input op, input sample_value, output ready);
endinterface

// ----- hw/rtl/rbs_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_out_if
// Result request channel: valid/ready handshake with the filtered pixel.
// ----------------------------------------------------------------------------
interface rbs_out_if;
    logic                         valid;
    logic                         ready;
    logic [rbs_pkg::SAMPLE_W-1:0] pixel_value;
    logic                         clipped;
    logic                         frame_last;

    modport source (output valid, output pixel_value, output clipped, output frame_last,
                    input ready);
    modport sink (input valid, input pixel_value, input clipped, input frame_last,
                  output ready);
endinterface

// ----- hw/rtl/raster_blur_sharpen_3x3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_blur_sharpen_3x3
// Streaming 3x3 weighted blur or unsharp mask over one raster band.
// ----------------------------------------------------------------------------
// Samples enter row-major on i_in, one request per pixel; once a raster is
// complete, drain requests (op = 1) flush the last row. Each pixel comes out
// on o_out one row and one column behind the input, with a saturation flag
// and a marker on the final pixel of the raster.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, which the block does not
// enforce. After reset both line stores are zeroed by a pass over every
// address, during which no request is accepted. A request that produces no
// pixel only updates the line stores and the window; one that produces a
// pixel also runs the shared weight multiplier and the bit-serial divider.
// The result waits in an output register; the next request is accepted
// while it waits, but the following result is held until the receiver
// takes the previous one.
// ----------------------------------------------------------------------------
module raster_blur_sharpen_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rbs_in_if.sink                          i_in,
    rbs_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rbs_pkg::WEIGHT_W-1:0]    i_cfg_data
);
    rbs_pkg::t_cfg     r_cfg;
    rbs_pkg::t_dp_cmd  w_cmd;
    rbs_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= rbs_pkg::WIDTH_W'(rbs_pkg::MAX_WIDTH);
            r_cfg.image_height  <= rbs_pkg::HEIGHT_W'(1);
            r_cfg.filter_mode   <= rbs_pkg::MODE_BLUR;
            r_cfg.center_weight <= '1;
            r_cfg.edge_weight   <= '0;
            r_cfg.corner_weight <= '0;
            r_cfg.sharpen_gain  <= rbs_pkg::GAIN_W'(4096);
        end else if (i_cfg_we) begin
            case (rbs_pkg::t_cfg_idx'(i_cfg_idx))
                rbs_pkg::CFG_IMAGE_WIDTH:
                    r_cfg.image_width <= i_cfg_data[rbs_pkg::WIDTH_W-1:0];
                rbs_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data;
                rbs_pkg::CFG_FILTER_MODE:   r_cfg.filter_mode   <= i_cfg_data[0];
                rbs_pkg::CFG_CENTER_WEIGHT: r_cfg.center_weight <= i_cfg_data;
                rbs_pkg::CFG_EDGE_WEIGHT:   r_cfg.edge_weight   <= i_cfg_data;
                rbs_pkg::CFG_CORNER_WEIGHT: r_cfg.corner_weight <= i_cfg_data;
                rbs_pkg::CFG_SHARPEN_GAIN:  r_cfg.sharpen_gain  <= i_cfg_data;
                default:                    r_cfg <= r_cfg;
            endcase
        end
    end

    rbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rbs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (w_cmd),
        .i_op          (i_in.op),
        .i_sample      (i_in.sample_value),
        .i_out_ready   (o_out.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_out.valid),
        .o_pixel_value (o_out.pixel_value),
        .o_clipped     (o_out.clipped),
        .o_frame_last  (o_out.frame_last)
    );

    assign i_in.ready = w_in_ready;
endmodule

// ----- hw/rtl/rbs_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbs_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbs_pkg::NUM_W-1:0]   i_num,
    input  logic [rbs_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [rbs_pkg::NUM_W-1:0]   o_quo
);
    localparam logic [rbs_pkg::QCNT_W-1:0] CNT_LAST = rbs_pkg::QCNT_W'(rbs_pkg::NUM_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [rbs_pkg::QCNT_W-1:0]  r_cnt;
    logic [rbs_pkg::DEN_W-1:0]   r_rem;
    logic [rbs_pkg::DEN_W-1:0]   r_den;
    logic [rbs_pkg::NUM_W-1:0]   r_quo;
    logic [rbs_pkg::DEN_W:0]     w_trial;
    logic [rbs_pkg::DEN_W:0]     w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[rbs_pkg::NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rbs_pkg::DEN_W-1:0] : w_trial[rbs_pkg::DEN_W-1:0];
            r_quo <= {r_quo[rbs_pkg::NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- hw/rtl/rbs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_datapath
// Line stores, 3x3 window, weighted accumulate, divider and result register.
// ----------------------------------------------------------------------------
module rbs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbs_pkg::t_cfg                 i_cfg,
    input  rbs_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_op,
    input  logic [rbs_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_out_ready,
    output rbs_pkg::t_dp_stat             o_stat,
    output logic                          o_out_valid,
    output logic [rbs_pkg::SAMPLE_W-1:0]  o_pixel_value,
    output logic                          o_clipped,
    output logic                          o_frame_last
);
    localparam int PROD_W = 2 * rbs_pkg::SAMPLE_W;
    localparam int NP_W   = rbs_pkg::SAMPLE_W + 4;
    localparam int SUM_W  = rbs_pkg::SAMPLE_W + 3;
    localparam int D_W    = NP_W + 1;
    localparam int GP_W   = rbs_pkg::GAIN_W + D_W;
    localparam int TOT_W  = GP_W + 1;

    localparam logic [rbs_pkg::IDX_W-1:0] IDX_CENTER = rbs_pkg::IDX_W'(rbs_pkg::CENTER);

    logic [rbs_pkg::SAMPLE_W-1:0] r_mem_up [rbs_pkg::MAX_WIDTH];
    logic [rbs_pkg::SAMPLE_W-1:0] r_mem_lo [rbs_pkg::MAX_WIDTH];
    logic [rbs_pkg::SAMPLE_W-1:0] r_rd_up;
    logic [rbs_pkg::SAMPLE_W-1:0] r_rd_lo;
    logic [rbs_pkg::SAMPLE_W-1:0] r_v;
    logic [rbs_pkg::SAMPLE_W-1:0] r_win [rbs_pkg::WIN_CELLS];

    logic [PROD_W-1:0]            r_prod;
    logic [rbs_pkg::NUM_W-1:0]    r_acc;
    logic [rbs_pkg::DEN_W-1:0]    r_wsum;
    logic [3:0]                   r_n;
    logic [SUM_W-1:0]             r_s;
    logic [NP_W-1:0]              r_np;
    logic signed [GP_W-1:0]       r_gprod;
    logic                         r_bypass;
    logic                         r_neg;

    logic                         r_out_valid;
    logic [rbs_pkg::SAMPLE_W-1:0] r_pixel;
    logic                         r_clip;
    logic                         r_last;

    logic [rbs_pkg::SAMPLE_W-1:0] w_cell;
    logic [rbs_pkg::WEIGHT_W-1:0] w_wt;
    logic signed [D_W-1:0]        w_d;
    logic [TOT_W-1:0]             w_total;
    logic [rbs_pkg::NUM_W-1:0]    w_num;
    logic [rbs_pkg::DEN_W-1:0]    w_den;
    logic                         w_div_done;
    logic [rbs_pkg::NUM_W-1:0]    w_quo;
    logic                         w_sharpen;

    assign w_sharpen = (i_cfg.filter_mode == rbs_pkg::MODE_SHARPEN);

    // Line stores: a read at accept, then the write of the same column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem_up[i_cmd.addr] <= i_cmd.clear ? '0 : r_rd_lo;
            r_mem_lo[i_cmd.addr] <= i_cmd.clear ? '0 : r_v;
        end
        if (i_cmd.mem_rd) begin
            r_rd_up <= r_mem_up[i_cmd.addr];
            r_rd_lo <= r_mem_lo[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v <= (i_op == rbs_pkg::OP_DRAIN) ? '0 : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rbs_pkg::WIN_CELLS; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= r_rd_up;
            r_win[5] <= r_rd_lo;
            r_win[8] <= r_v;
        end
    end

    assign w_cell = r_win[i_cmd.mac_idx];

    always_comb begin
        case (i_cmd.mac_idx)
            4'd0, 4'd2, 4'd6, 4'd8: w_wt = i_cfg.corner_weight;
            4'd1, 4'd3, 4'd5, 4'd7: w_wt = i_cfg.edge_weight;
            default:                w_wt = i_cfg.center_weight;
        endcase
    end

    // Products are registered and added to the sum in the next cycle; the flush adds the last.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_prod <= '0;
            r_acc  <= '0;
            r_wsum <= '0;
            r_n    <= '0;
            r_s    <= '0;
        end else if (i_cmd.mac_step) begin
            r_prod <= i_cmd.mac_ok ? w_wt * w_cell : '0;
            r_acc  <= r_acc + rbs_pkg::NUM_W'(r_prod);
            if (i_cmd.mac_ok) begin
                r_wsum <= r_wsum + rbs_pkg::DEN_W'(w_wt);
                if (i_cmd.mac_idx != IDX_CENTER) begin
                    r_n <= r_n + 1'b1;
                    r_s <= r_s + SUM_W'(w_cell);
                end
            end
        end else if (i_cmd.mac_flush) begin
            r_acc <= r_acc + rbs_pkg::NUM_W'(r_prod);
        end
    end

    assign w_d = $signed({1'b0, r_np}) - $signed({2'b00, r_s});

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_np <= r_n * r_win[rbs_pkg::CENTER];
        end
        if (i_cmd.gain) begin
            r_gprod <= $signed(i_cfg.sharpen_gain) * w_d;
        end
    end

    // Sharpen numerator: 4096*n*p + gain*(n*p - S) + 2048*n, in two's complement.
    assign w_total = {{(TOT_W-NP_W-12){1'b0}}, r_np, 12'b0}
                   + {r_gprod[GP_W-1], r_gprod}
                   + {{(TOT_W-15){1'b0}}, r_n, 11'b0};

    assign w_num = w_sharpen ? w_total[rbs_pkg::NUM_W-1:0]
                             : r_acc + rbs_pkg::NUM_W'(r_wsum[rbs_pkg::DEN_W-1:1]);
    assign w_den = w_sharpen ? rbs_pkg::DEN_W'({r_n, 12'b0}) : r_wsum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_bypass <= w_sharpen ? (r_n == '0) : (r_wsum == '0);
            r_neg    <= w_sharpen & w_total[TOT_W-1];
        end
    end

    rbs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_last <= i_cmd.frame_last;
            if (r_bypass) begin
                r_pixel <= r_win[rbs_pkg::CENTER];
                r_clip  <= 1'b0;
            end else if (r_neg) begin
                r_pixel <= '0;
                r_clip  <= 1'b1;
            end else if (w_quo[rbs_pkg::NUM_W-1:rbs_pkg::SAMPLE_W] != '0) begin
                r_pixel <= '1;
                r_clip  <= 1'b1;
            end else begin
                r_pixel <= w_quo[rbs_pkg::SAMPLE_W-1:0];
                r_clip  <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_pixel;
    assign o_clipped       = r_clip;
    assign o_frame_last    = r_last;
endmodule

// ----- hw/rtl/rbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: line store clearing, raster counters and per-pixel steps.
// ----------------------------------------------------------------------------
module rbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbs_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    output logic               o_in_ready,
    input  rbs_pkg::t_dp_stat  i_stat,
    output rbs_pkg::t_dp_cmd   o_cmd
);
    localparam logic [rbs_pkg::IDX_W-1:0] K_LAST = rbs_pkg::IDX_W'(rbs_pkg::WIN_CELLS - 1);
    localparam logic [rbs_pkg::WIDTH_W-1:0] W_MAX = rbs_pkg::WIDTH_W'(rbs_pkg::MAX_WIDTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SHIFT, S_MAC, S_FLUSH, S_PREP, S_GAIN, S_LOAD, S_DIV, S_OUT
    } t_state;

    t_state                        r_state;
    logic [rbs_pkg::ADDR_W-1:0]    r_clr;
    logic [rbs_pkg::ADDR_W-1:0]    r_in_col;
    logic [rbs_pkg::HEIGHT_W-1:0]  r_in_row;
    logic [rbs_pkg::ADDR_W-1:0]    r_out_col;
    logic [rbs_pkg::HEIGHT_W-1:0]  r_out_row;
    logic [rbs_pkg::IDX_W-1:0]     r_k;
    logic [rbs_pkg::WIN_CELLS-1:0] r_ok;

    logic [rbs_pkg::WIDTH_W-1:0]   w_w;
    logic [rbs_pkg::HEIGHT_W-1:0]  w_h;
    logic                          w_complete;
    logic                          w_primed;
    logic                          w_take;
    logic                          w_in_wrap;
    logic                          w_rv0, w_rv2, w_cv0, w_cv2;
    logic                          w_last;
    logic [rbs_pkg::WIN_CELLS-1:0] w_ok;

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_w = rbs_pkg::WIDTH_W'(1);
        end else if (i_cfg.image_width > W_MAX) begin
            w_w = W_MAX;
        end else begin
            w_w = i_cfg.image_width;
        end
        w_h = (i_cfg.image_height == '0) ? rbs_pkg::HEIGHT_W'(1) : i_cfg.image_height;
    end

    assign w_complete = r_in_row >= w_h;
    assign w_primed   = (r_in_row >= rbs_pkg::HEIGHT_W'(2))
                      || (r_in_row == rbs_pkg::HEIGHT_W'(1) && r_in_col != '0);
    assign w_take     = (r_state == S_IDLE) && i_in_valid
                      && ((i_in_op == rbs_pkg::OP_DRAIN) == w_complete);
    assign w_in_wrap  = (rbs_pkg::WIDTH_W'(r_in_col) + 1'b1) >= w_w;

    assign w_rv0  = r_out_row != '0;
    assign w_rv2  = (rbs_pkg::HEIGHT_W'(r_out_row) + 17'd1) < {1'b0, w_h};
    assign w_cv0  = r_out_col != '0;
    assign w_cv2  = (rbs_pkg::WIDTH_W'(r_out_col) + 1'b1) < w_w;
    assign w_last = ~w_rv2 & ~w_cv2;

    always_comb begin
        w_ok[0] = w_rv0 & w_cv0;
        w_ok[1] = w_rv0;
        w_ok[2] = w_rv0 & w_cv2;
        w_ok[3] = w_cv0;
        w_ok[4] = 1'b1;
        w_ok[5] = w_cv2;
        w_ok[6] = w_rv2 & w_cv0;
        w_ok[7] = w_rv2;
        w_ok[8] = w_rv2 & w_cv2;
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.addr = (r_state == S_CLEAR) ? r_clr : r_in_col;
        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.clear  = 1'b1;
            end
            S_IDLE: begin
                o_cmd.mem_rd  = w_take;
                o_cmd.capture = w_take;
            end
            S_SHIFT: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.shift     = 1'b1;
                o_cmd.mac_start = 1'b1;
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                o_cmd.mac_ok   = r_ok[r_k];
                o_cmd.mac_idx  = r_k;
            end
            S_FLUSH: o_cmd.mac_flush = 1'b1;
            S_PREP:  o_cmd.prep      = 1'b1;
            S_GAIN:  o_cmd.gain      = 1'b1;
            S_LOAD:  o_cmd.div_start = 1'b1;
            S_OUT: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.frame_last = w_last;
            end
            default: o_cmd.addr = r_in_col;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_k       <= '0;
            r_ok      <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (w_in_wrap) begin
                        r_in_col <= '0;
                        if (r_in_row != '1) begin
                            r_in_row <= r_in_row + 1'b1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                    r_ok    <= w_ok;
                    r_k     <= '0;
                    r_state <= w_primed ? S_MAC : S_IDLE;
                end
                S_MAC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: r_state <= S_PREP;
                S_PREP:  r_state <= S_GAIN;
                S_GAIN:  r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_stat.out_free) begin
                        // The final pixel of a raster restarts the input and output counters.
                        if (w_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                        end else if (!w_cv2) begin
                            r_out_col <= '0;
                            if (r_out_row != '1) begin
                                r_out_row <= r_out_row + 1'b1;
                            end
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- bench/raster_blur_sharpen_3x3_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_blur_sharpen_3x3_tb
// Self-checking bench for the streaming 3x3 blur / unsharp mask filter.
// A short table of directed requests covers the corner cases, then random
// rasters of many shapes and kernels follow. Every accepted sample request
// is run through a behavioral filter model and each pixel on the output
// channel is compared field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module raster_blur_sharpen_3x3_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 440;
    localparam int WIDE_COLS      = 64;

    typedef struct {
        logic [rbs_pkg::SAMPLE_W-1:0] pix;
        logic                         clip;
        logic                         last;
    } t_pixel;

    typedef enum logic { ROW_CFG, ROW_REQ } t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        rbs_pkg::t_cfg_idx            idx;
        logic [rbs_pkg::WEIGHT_W-1:0] data;
        logic                         op;
        logic [rbs_pkg::SAMPLE_W-1:0] val;
        logic                         chk;
        t_pixel                       exp_px;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic                         i_cfg_we;
    rbs_pkg::t_cfg_idx            i_cfg_idx;
    logic [rbs_pkg::WEIGHT_W-1:0] i_cfg_data;

    rbs_in_if  in_ch ();
    rbs_out_if out_ch ();

    raster_blur_sharpen_3x3 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Filter model state.
    logic [12:0]                  m_width;
    logic [15:0]                  m_height;
    logic                         m_mode;
    logic [15:0]                  m_cw, m_ew, m_kw, m_gain;
    logic [rbs_pkg::SAMPLE_W-1:0] store_up [rbs_pkg::MAX_WIDTH];
    logic [rbs_pkg::SAMPLE_W-1:0] store_lo [rbs_pkg::MAX_WIDTH];
    logic [rbs_pkg::SAMPLE_W-1:0] win [9];
    int unsigned                  in_col, in_row, out_col, out_row;

    t_pixel pending_px [$];
    bit     frame_done;
    bit     hold_done;
    int     errors;
    int     tx_idle_pct, rx_idle_pct;
    int     hold_left;
    int     quiet_cycles = 0;

    task automatic report(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // Advances the model by one request; returns 1 when a pixel comes out.
    function automatic bit filter_step(logic op, logic [rbs_pkg::SAMPLE_W-1:0] sample,
                                       output t_pixel px);
        int unsigned w, h, ix;
        bit          primed, full, rv, cv;
        bit          ok [9];
        longint      num, den, n, s, total, q, p, wt;
        w = (m_width < 1) ? 1
          : (m_width > rbs_pkg::MAX_WIDTH ? rbs_pkg::MAX_WIDTH : m_width);
        h = (m_height < 1) ? 1 : m_height;
        px = '{default: '0};
        full = in_row >= h;
        if (op == rbs_pkg::OP_SAMPLE && full) return 0;
        if (op == rbs_pkg::OP_DRAIN && !full) return 0;
        if (op == rbs_pkg::OP_DRAIN) sample = '0;
        primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
        ix = (in_col < rbs_pkg::MAX_WIDTH) ? in_col : rbs_pkg::MAX_WIDTH - 1;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = store_up[ix];
        win[5] = store_lo[ix];
        win[8] = sample;
        store_up[ix] = store_lo[ix];
        store_lo[ix] = sample;
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < 16'hFFFF) in_row++;
        end else begin
            in_col++;
        end
        if (!primed) return 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
                rv = (r == 0) ? out_row > 0 : (r == 2) ? out_row + 1 < h : 1'b1;
                cv = (c == 0) ? out_col > 0 : (c == 2) ? out_col + 1 < w : 1'b1;
                ok[r*3+c] = rv && cv;
            end
        p = win[rbs_pkg::CENTER];
        px.pix = win[rbs_pkg::CENTER];
        if (m_mode == rbs_pkg::MODE_BLUR) begin
            num = 0;
            den = 0;
            for (int k = 0; k < 9; k++) begin
                if (!ok[k]) continue;
                wt = (k == rbs_pkg::CENTER) ? m_cw : (k % 2 == 1) ? m_ew : m_kw;
                num += wt * win[k];
                den += wt;
            end
            if (den != 0) begin
                q = (num + den / 2) / den;
                if (q > 65535) begin
                    q = 65535;
                    px.clip = 1'b1;
                end
                px.pix = q[15:0];
            end
        end else begin
            n = 0;
            s = 0;
            for (int k = 0; k < 9; k++)
                if (ok[k] && k != rbs_pkg::CENTER) begin
                    n++;
                    s += win[k];
                end
            if (n != 0) begin
                total = 4096 * n * p + longint'($signed(m_gain)) * (n * p - s) + 2048 * n;
                q = floor_div(total, 4096 * n);
                if (q < 0) begin
                    q = 0;
                    px.clip = 1'b1;
                end
                if (q > 65535) begin
                    q = 65535;
                    px.clip = 1'b1;
                end
                px.pix = q[15:0];
            end
        end
        px.last = out_row + 1 >= h && out_col + 1 >= w;
        if (px.last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_row < 16'hFFFF) out_row++;
        end else begin
            out_col++;
        end
        return 1;
    endfunction

    task automatic write_reg(rbs_pkg::t_cfg_idx idx, logic [rbs_pkg::WEIGHT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rbs_pkg::CFG_IMAGE_WIDTH:   m_width  = data[12:0];
            rbs_pkg::CFG_IMAGE_HEIGHT:  m_height = data;
            rbs_pkg::CFG_FILTER_MODE:   m_mode   = data[0];
            rbs_pkg::CFG_CENTER_WEIGHT: m_cw     = data;
            rbs_pkg::CFG_EDGE_WEIGHT:   m_ew     = data;
            rbs_pkg::CFG_CORNER_WEIGHT: m_kw     = data;
            rbs_pkg::CFG_SHARPEN_GAIN:  m_gain   = data;
            default: ;
        endcase
    endtask

    // Lets the block drain; an ignored request may still be in flight.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_req(logic op, logic [rbs_pkg::SAMPLE_W-1:0] val, logic chk,
                            t_pixel want);
        t_pixel px;
        bit     has;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.sample_value <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        has = filter_step(op, val, px);
        if (has && px.last) frame_done = 1;
        if (chk) px = want;
        if (has || chk) pending_px.push_back(px);
    endtask

    function automatic logic [rbs_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return rbs_pkg::SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic set_idling(int done);
        if (done < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 26;
            rx_idle_pct = 74;
        end else if (done < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 74;
            rx_idle_pct = 26;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic drain_frame();
        t_pixel none;
        none = '{default: '0};
        while (!frame_done) send_req(rbs_pkg::OP_DRAIN, rand_sample(), 1'b0, none);
    endtask

    // One well-formed raster with random content and some stray requests.
    task automatic run_raster(int w, int h, ref int done);
        t_pixel none;
        none = '{default: '0};
        wait_idle();
        write_reg(rbs_pkg::CFG_IMAGE_WIDTH, 16'(w));
        write_reg(rbs_pkg::CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(rbs_pkg::CFG_FILTER_MODE, 16'($urandom_range(1)));
        write_reg(rbs_pkg::CFG_CENTER_WEIGHT, rand_weight());
        write_reg(rbs_pkg::CFG_EDGE_WEIGHT, rand_weight());
        write_reg(rbs_pkg::CFG_CORNER_WEIGHT, rand_weight());
        case ($urandom_range(5))
            0: write_reg(rbs_pkg::CFG_SHARPEN_GAIN, 16'h8000);
            1: write_reg(rbs_pkg::CFG_SHARPEN_GAIN, 16'h7FFF);
            default: write_reg(rbs_pkg::CFG_SHARPEN_GAIN, 16'($urandom_range(65535)));
        endcase
        // The receiver holds off while samples keep coming, so the block
        // backs up and stalls its input.
        if (done > 100 && !hold_done && w * h >= 4) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
        end
        frame_done = 0;
        for (int k = 0; k < w * h; k++) begin
            set_idling(done);
            if ($urandom_range(99) < 3) send_req(rbs_pkg::OP_DRAIN, rand_sample(), 1'b0, none);
            send_req(rbs_pkg::OP_SAMPLE, rand_sample(), 1'b0, none);
            done++;
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(2, 1))
                send_req(rbs_pkg::OP_SAMPLE, rand_sample(), 1'b0, none);
        drain_frame();
        done += w + 1;
    endtask

    function automatic t_row cfg_row(rbs_pkg::t_cfg_idx idx, logic [15:0] data);
        return '{ROW_CFG, idx, data, 1'b0, '0, 1'b0, '{default: '0}};
    endfunction

    function automatic t_row req_row(logic op, logic [15:0] val);
        return '{ROW_REQ, rbs_pkg::CFG_IMAGE_WIDTH, '0, op, val, 1'b0, '{default: '0}};
    endfunction

    function automatic t_row chk_row(logic op, logic [15:0] val, logic [15:0] pix,
                                     logic clip, logic last);
        return '{ROW_REQ, rbs_pkg::CFG_IMAGE_WIDTH, '0, op, val, 1'b1, '{pix, clip, last}};
    endfunction

    // Result side: checks every accepted pixel and paces ready.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_px.size() == 0) begin
                report("unexpected pixel_value", out_ch.pixel_value, 0);
            end else begin
                want = pending_px.pop_front();
                if (out_ch.pixel_value !== want.pix)
                    report("pixel_value", out_ch.pixel_value, want.pix);
                if (out_ch.clipped !== want.clip)
                    report("clipped", out_ch.clipped, want.clip);
                if (out_ch.frame_last !== want.last)
                    report("frame_last", out_ch.frame_last, want.last);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("** raster_blur_sharpen_3x3: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row   rows [$];
        t_pixel none;
        int     done;
        none = '{default: '0};
        errors = 0;
        done = 0;
        hold_left = 0;
        hold_done = 0;
        tx_idle_pct = 26;
        rx_idle_pct = 74;
        frame_done = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rbs_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = rbs_pkg::OP_SAMPLE;
        in_ch.sample_value = '0;
        out_ch.ready = 1'b0;
        m_width = 13'd4096;
        m_height = 16'd1;
        m_mode = rbs_pkg::MODE_BLUR;
        m_cw = 16'hFFFF;
        m_ew = '0;
        m_kw = '0;
        m_gain = 16'd4096;
        for (int k = 0; k < rbs_pkg::MAX_WIDTH; k++) begin
            store_up[k] = '0;
            store_lo[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single pixel rasters show the centre sample; a drain before the
        // raster is complete and a sample after it is complete are ignored.
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_WIDTH, 16'd1));
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_HEIGHT, 16'd1));
        rows.push_back(cfg_row(rbs_pkg::CFG_FILTER_MODE, 16'(rbs_pkg::MODE_BLUR)));
        rows.push_back(req_row(rbs_pkg::OP_DRAIN, 16'h1234));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'hFFFF));
        rows.push_back(req_row(rbs_pkg::OP_DRAIN, 16'h0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'h0, 16'hFFFF, 1'b0, 1'b1));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'd5));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'd7));
        rows.push_back(req_row(rbs_pkg::OP_DRAIN, 16'h0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'hFFFF, 16'd5, 1'b0, 1'b1));
        rows.push_back(cfg_row(rbs_pkg::CFG_FILTER_MODE, 16'(rbs_pkg::MODE_SHARPEN)));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'd1234));
        rows.push_back(req_row(rbs_pkg::OP_DRAIN, 16'h0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'h0, 16'd1234, 1'b0, 1'b1));
        // With every weight zero the blur passes the centre sample through.
        rows.push_back(cfg_row(rbs_pkg::CFG_CENTER_WEIGHT, 16'h0));
        rows.push_back(cfg_row(rbs_pkg::CFG_FILTER_MODE, 16'(rbs_pkg::MODE_BLUR)));
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_WIDTH, 16'd2));
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_HEIGHT, 16'd2));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'h0));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'hFFFF));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'hFFFF));
        rows.push_back(chk_row(rbs_pkg::OP_SAMPLE, 16'h0, 16'h0, 1'b0, 1'b0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'h0, 16'hFFFF, 1'b0, 1'b0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'h0, 16'hFFFF, 1'b0, 1'b0));
        rows.push_back(chk_row(rbs_pkg::OP_DRAIN, 16'h0, 16'h0, 1'b0, 1'b1));
        // Sharpening at full gain saturates both ways.
        rows.push_back(cfg_row(rbs_pkg::CFG_FILTER_MODE, 16'(rbs_pkg::MODE_SHARPEN)));
        rows.push_back(cfg_row(rbs_pkg::CFG_SHARPEN_GAIN, 16'h7FFF));
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_WIDTH, 16'd3));
        rows.push_back(cfg_row(rbs_pkg::CFG_IMAGE_HEIGHT, 16'd1));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'h0));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'hFFFF));
        rows.push_back(req_row(rbs_pkg::OP_SAMPLE, 16'h0));
        repeat (4) rows.push_back(req_row(rbs_pkg::OP_DRAIN, 16'h0));

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(rows[k].idx, rows[k].data);
            end else begin
                send_req(rows[k].op, rows[k].val, rows[k].chk, rows[k].exp_px);
            end
        end

        while (done < RANDOM_ITEMS) begin
            if ($urandom_range(9) == 0)
                run_raster($urandom_range(3, 1), $urandom_range(3, 1), done);
            else
                run_raster($urandom_range(12, 1), $urandom_range(6, 1), done);
        end

        // Tallest raster: run part of it, then shorten it so the drains close it.
        wait_idle();
        write_reg(rbs_pkg::CFG_IMAGE_WIDTH, 16'd1);
        write_reg(rbs_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
        frame_done = 0;
        repeat (20) send_req(rbs_pkg::OP_SAMPLE, rand_sample(), 1'b0, none);
        wait_idle();
        write_reg(rbs_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        drain_frame();

        // A wide raster, one row.
        run_raster(WIDE_COLS, 1, done);

        wait_idle();
        if (errors == 0) begin
            $display("** raster_blur_sharpen_3x3: PASSED **");
        end else begin
            $display("** raster_blur_sharpen_3x3: FAILED **");
        end
        $finish;
    end

endmodule

// ----- raster_blur_sharpen_3x3.f -----
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_in_if.sv
hw/rtl/rbs_out_if.sv
hw/rtl/rbs_divider.sv
hw/rtl/rbs_datapath.sv
hw/rtl/rbs_ctrl.sv
hw/rtl/raster_blur_sharpen_3x3.sv
bench/raster_blur_sharpen_3x3_tb.sv
